>>> rtl/assert_macros.svh
// Assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, muted in reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, muted in reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/spq_pkg.sv
package spq_pkg;

  // Number of cells in the chain
  localparam int unsigned DEPTH = 64;
  // Width of the fill count, wide enough to hold DEPTH itself
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PRI_W  = 16;
  localparam int unsigned OCC_W  = 7;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Input word
  typedef struct packed {
    cmd_e                      command;
    logic signed [DATA_W-1:0]  item_data;
    logic        [PRI_W-1:0]   item_priority;
  } in_word_t;

  // Result word
  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  removed_data;
    logic        [PRI_W-1:0]   removed_priority;
    logic        [OCC_W-1:0]   occupancy;
  } out_word_t;

  // One stored entry
  typedef struct packed {
    logic [PRI_W-1:0]  pri;
    logic [DATA_W-1:0] data;
  } entry_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic ins;    // an insert is being applied this cycle
    logic valid;  // cell lies below the fill count
    logic tail;   // cell holds the last entry
  } cell_ctrl_t;

endpackage

>>> rtl/spq_cell.sv
// One slot of the sorted chain: keeps its entry, takes the new one or
// the left neighbour's on an insert.
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t    new_i,
  input  spq_pkg::entry_t    prev_i,
  input  logic               prev_keep_i,
  output logic               keep_o,
  output spq_pkg::entry_t    entry_o,
  output spq_pkg::entry_t    sel_o
);

  spq_pkg::entry_t entry_q;

  // Held entry, passed on to the right neighbour
  assign entry_o = entry_q;

  // Entry stays put when it is held and ranks at or above the new one
  assign keep_o = ctrl_i.valid && (entry_q.pri >= new_i.pri);

  // Tail entry is driven out for the remove path, zero otherwise
  assign sel_o = ctrl_i.tail ? entry_q : '0;

  // Insert: first non-kept cell takes the new word, the rest shift right
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && !keep_o) begin
      entry_q <= prev_keep_i ? new_i : prev_i;
    end
  end

endmodule

>>> rtl/sorted_priority_queue.sv
// Channel  Direction  Word type          Handshake
// in       input      spq_pkg::in_word_t  in_valid_i / in_stall_o
// out      output     spq_pkg::out_word_t out_valid_o / out_stall_i
//
// One command per cycle unless stalled: all cells compare against the new
// priority in parallel and shift in the same edge; the result is registered
// in the output register, or in the skid register while the output stalls.
// Reset empties the queue (fill count to zero); cell contents are not cleared.
// A skid register behind the output lets one more command in while a result
// is stalled; input stalls only when that skid register is occupied.
module sorted_priority_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spq_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spq_pkg::out_word_t out_word_o
);

  localparam int unsigned CW = spq_pkg::CNT_W;

  logic [CW-1:0] count_q, count_d;
  logic          accept, full, empty, do_ins, do_rem;

  spq_pkg::entry_t     new_entry;
  spq_pkg::entry_t     cell_entry [spq_pkg::DEPTH];
  spq_pkg::entry_t     cell_sel   [spq_pkg::DEPTH];
  logic                cell_keep  [spq_pkg::DEPTH];
  spq_pkg::cell_ctrl_t cell_ctrl  [spq_pkg::DEPTH];
  spq_pkg::entry_t     tail_entry;

  spq_pkg::out_word_t res, out_q, skid_q;
  logic               out_v_q, skid_v_q, pop;

  assign accept = in_valid_i && !in_stall_o;
  assign full   = (count_q == CW'(spq_pkg::DEPTH));
  assign empty  = (count_q == '0);
  assign do_ins = accept && (in_word_i.command == spq_pkg::CMD_INSERT) && !full;
  assign do_rem = accept && (in_word_i.command == spq_pkg::CMD_REMOVE) && !empty;

  assign new_entry.pri  = in_word_i.item_priority;
  assign new_entry.data = in_word_i.item_data;

  // Fill count
  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CW'(1);
    end else if (do_rem) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Cell chain
  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    assign cell_ctrl[i].ins   = do_ins;
    assign cell_ctrl[i].valid = (CW'(i) < count_q);
    assign cell_ctrl[i].tail  = (CW'(i + 1) == count_q);

    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl[i]),
        .new_i       (new_entry),
        .prev_i      (new_entry),
        .prev_keep_i (1'b1),
        .keep_o      (cell_keep[i]),
        .entry_o     (cell_entry[i]),
        .sel_o       (cell_sel[i])
      );
    end else begin : g_body
      spq_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl[i]),
        .new_i       (new_entry),
        .prev_i      (cell_entry[i-1]),
        .prev_keep_i (cell_keep[i-1]),
        .keep_o      (cell_keep[i]),
        .entry_o     (cell_entry[i]),
        .sel_o       (cell_sel[i])
      );
    end
  end

  // Tail pick: at most one cell, the tail, drives its entry onto the select
  always_comb begin
    tail_entry = '0;
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      tail_entry = tail_entry | cell_sel[i];
    end
  end

  // Result word
  always_comb begin
    res                  = '0;
    res.occupancy        = spq_pkg::OCC_W'(count_d);
    if (in_word_i.command == spq_pkg::CMD_INSERT) begin
      res.status = full ? spq_pkg::ST_OVERFLOW : spq_pkg::ST_OK;
    end else if (empty) begin
      res.status = spq_pkg::ST_UNDERFLOW;
    end else begin
      res.status           = spq_pkg::ST_OK;
      res.removed_data     = tail_entry.data;
      res.removed_priority = tail_entry.pri;
    end
  end

  // Output register plus skid
  assign pop         = out_v_q && !out_stall_i;
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;
  assign in_stall_o  = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_v_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

endmodule

>>> rtl/spq_checker.sv
`include "assert_macros.svh"

// Port-level checks on the queue
module spq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input spq_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input spq_pkg::out_word_t out_word_o
);

  // A stalled result word stays offered and unchanged
  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o))

  // A stalled command word stays offered and unchanged
  `ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_word_i))

  // Overflow only when full, and carries no removed entry
  `ASSERT_IMPL(a_overflow_full,
    out_valid_o && (out_word_o.status == spq_pkg::ST_OVERFLOW),
    (out_word_o.occupancy == spq_pkg::OCC_W'(spq_pkg::DEPTH)) &&
    (out_word_o.removed_data == '0) && (out_word_o.removed_priority == '0))

  // Underflow only when empty, and carries no removed entry
  `ASSERT_IMPL(a_underflow_empty,
    out_valid_o && (out_word_o.status == spq_pkg::ST_UNDERFLOW),
    (out_word_o.occupancy == '0) &&
    (out_word_o.removed_data == '0) && (out_word_o.removed_priority == '0))

  // Input may only stall while a result is waiting
  `ASSERT_IMPL(a_stall_cause, in_stall_o, out_valid_o)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

>>> tb/sorted_priority_queue_tb.sv
`timescale 1ns / 100ps

module sorted_priority_queue_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_WORDS = 150;
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned DRAIN_WAIT  = 20;

  // Shadow of the sorted array; every accepted command queues the result it must produce
  class spq_scoreboard;
    spq_pkg::entry_t    slots [spq_pkg::DEPTH];
    int unsigned        fill = 0;
    spq_pkg::out_word_t awaited [$];
    int unsigned        n_errors = 0;
    int unsigned        n_checked = 0;
    int unsigned        n_overflow = 0;
    int unsigned        n_underflow = 0;
    int unsigned        peak_fill = 0;

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Apply one accepted command to the shadow queue
    function void note_command(spq_pkg::in_word_t w);
      spq_pkg::out_word_t r;
      int unsigned        pos;
      int unsigned        k;
      r = '0;
      r.status = spq_pkg::ST_OK;
      if (w.command == spq_pkg::CMD_INSERT) begin
        if (fill >= spq_pkg::DEPTH) begin
          r.status = spq_pkg::ST_OVERFLOW;
          n_overflow++;
        end else begin
          // new entry goes behind everything of equal or higher priority
          pos = 0;
          while (pos < fill && slots[pos].pri >= w.item_priority) pos++;
          for (k = fill; k > pos; k--) slots[k] = slots[k-1];
          slots[pos].pri  = w.item_priority;
          slots[pos].data = w.item_data;
          fill++;
          if (fill > peak_fill) peak_fill = fill;
        end
      end else begin
        if (fill == 0) begin
          r.status = spq_pkg::ST_UNDERFLOW;
          n_underflow++;
        end else begin
          fill--;
          r.removed_data     = slots[fill].data;
          r.removed_priority = slots[fill].pri;
        end
      end
      r.occupancy = spq_pkg::OCC_W'(fill);
      awaited.push_back(r);
    endfunction

    function void field_check(string field, logic [31:0] expv, logic [31:0] gotv);
      if (expv !== gotv) begin
        n_errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, expv, gotv);
      end
    endfunction

    // Compare one result word with the oldest prediction
    function void check_result(spq_pkg::out_word_t got);
      spq_pkg::out_word_t want;
      if (awaited.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = awaited.pop_front();
      n_checked++;
      field_check("status", 32'(want.status), 32'(got.status));
      field_check("removed_data", want.removed_data, got.removed_data);
      field_check("removed_priority", 32'(want.removed_priority), 32'(got.removed_priority));
      field_check("occupancy", 32'(want.occupancy), 32'(got.occupancy));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  spq_pkg::in_word_t  in_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  spq_pkg::out_word_t out_word_o;

  spq_scoreboard sb;
  int unsigned   cycle_cnt = 0;
  int unsigned   words_sent = 0;
  bit            sender_quiet = 1'b0;
  bit            hold_request = 1'b0;

  sorted_priority_queue i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Watchdog
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
    $display("Verification failed");
    $finish;
  end

  // Monitors: note accepted commands, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_command(in_word_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_word_o);
  end

  // Receiver: random stalls, a quiet stretch, and one long hold on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_stall_i <= 1'b1;
      end else if (sb.n_checked >= 350 && sb.n_checked < 450) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 15);
      end
    end
  end

  // Offer one command word, with random idle cycles first, and wait for acceptance
  task automatic issue_cmd(spq_pkg::cmd_e c, logic [spq_pkg::DATA_W-1:0] d,
                           logic [spq_pkg::PRI_W-1:0] p);
    spq_pkg::in_word_t w;
    w.command       = c;
    w.item_data     = d;
    w.item_priority = p;
    if (!sender_quiet) begin
      while ($urandom_range(99) < 15) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // Priorities cluster on a few values now and then so that ties are common
  function automatic logic [spq_pkg::PRI_W-1:0] pick_priority();
    case ($urandom_range(3))
      0:       return spq_pkg::PRI_W'($urandom_range(3));
      1:       return $urandom_range(1) ? '1 : '0;
      default: return spq_pkg::PRI_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned insert_pct [4];
    int unsigned ph;
    int unsigned n;
    insert_pct = '{85, 15, 90, 10};
    sb = new();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty remove, field extremes, ties at head and tail, drain past empty
    issue_cmd(spq_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
    issue_cmd(spq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
    issue_cmd(spq_pkg::CMD_INSERT, 32'h8000_0000, 16'h0000);
    issue_cmd(spq_pkg::CMD_INSERT, 32'h0000_0000, 16'h0000);
    issue_cmd(spq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'h8000);
    issue_cmd(spq_pkg::CMD_INSERT, 32'h0000_0005, 16'hFFFF);
    issue_cmd(spq_pkg::CMD_INSERT, 32'h5555_AAAA, 16'h7FFF);
    issue_cmd(spq_pkg::CMD_REMOVE, 32'hAAAA_5555, 16'h5555);
    issue_cmd(spq_pkg::CMD_REMOVE, 32'h0000_0000, 16'h0000);
    issue_cmd(spq_pkg::CMD_REMOVE, 32'h0000_0000, 16'h0000);
    issue_cmd(spq_pkg::CMD_REMOVE, 32'h0000_0000, 16'h0000);
    issue_cmd(spq_pkg::CMD_REMOVE, 32'h0000_0000, 16'h0000);
    issue_cmd(spq_pkg::CMD_REMOVE, 32'h0000_0000, 16'h0000);
    issue_cmd(spq_pkg::CMD_REMOVE, 32'h1234_5678, 16'h00FF);
    issue_cmd(spq_pkg::CMD_INSERT, 32'h0000_0001, 16'h0007);
    issue_cmd(spq_pkg::CMD_INSERT, 32'h0000_0002, 16'h0007);
    issue_cmd(spq_pkg::CMD_INSERT, 32'h0000_0003, 16'h0007);
    issue_cmd(spq_pkg::CMD_INSERT, 32'h0000_0004, 16'h0008);
    issue_cmd(spq_pkg::CMD_REMOVE, 32'h0000_0000, 16'h0000);
    issue_cmd(spq_pkg::CMD_REMOVE, 32'h0000_0000, 16'h0000);
    issue_cmd(spq_pkg::CMD_REMOVE, 32'h0000_0000, 16'h0000);
    issue_cmd(spq_pkg::CMD_REMOVE, 32'h0000_0000, 16'h0000);

    // Random: phases alternate between filling past full and draining past empty
    for (ph = 0; ph < 4; ph++) begin
      for (n = 0; n < PHASE_WORDS; n++) begin
        sender_quiet = (words_sent >= 150 && words_sent < 250);
        if (words_sent == 260) hold_request = 1'b1;
        if (words_sent == 480) begin
          // let the block run dry before carrying on
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (sb.pending() != 0);
        end
        issue_cmd(($urandom_range(99) < insert_pct[ph]) ? spq_pkg::CMD_INSERT
                                                         : spq_pkg::CMD_REMOVE,
                  $urandom, pick_priority());
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d commands, checked %0d results, peak occupancy %0d",
             words_sent, sb.n_checked, sb.peak_fill);
    $display("Overflows %0d, underflows %0d, errors %0d",
             sb.n_overflow, sb.n_underflow, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
